[rtl/core/sbte_pkg.sv]
package sbte_pkg;

  localparam logic [7:0] CHAR_OFFSET  = 8'd33;
  localparam logic [7:0] NEWLINE_CHAR = 8'd10;
  localparam logic [5:0] LINE_RESET   = 6'd20;
  localparam int         QUEUE_DEPTH  = 2;

  localparam logic [2:0] CI_FIRST   = 3'd0;
  localparam logic [2:0] CI_SECOND  = 3'd1;
  localparam logic [2:0] CI_THIRD   = 3'd2;
  localparam logic [2:0] CI_FOURTH  = 3'd3;
  localparam logic [2:0] CI_NEWLINE = 3'd4;

  typedef struct packed {
    logic [7:0] a;
    logic [7:0] b;
    logic [7:0] c;
    logic [2:0] last_idx;
    logic       final_job;
  } job_t;

endpackage

[rtl/core/six_bit_text_encoder_unit.sv]
// A byte that completes a group or ends the message is written into the queue
// as a request; the back end then registers its first character on the output.
// Throughput: one character per cycle while a request is queued and out_stall
// is low; a group of three bytes gives four characters, or five with a newline.
// Reset (rst, synchronous): clears pending bytes, group count, queue and output
// valid, and sets the groups-per-line setting to 20.
module six_bit_text_encoder_unit #(
  parameter int QUEUE_DEPTH = sbte_pkg::QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] data_byte,
  input  logic       is_final_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] text_char,
  output logic       is_final_char,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [5:0] groups_per_line
);

  sbte_pkg::job_t push_job;
  sbte_pkg::job_t head;
  logic           push;
  logic           pop;
  logic           queue_full;
  logic           queue_empty;

  assign cfg_ready = 1'b1;

  sbte_front u_front (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .data_byte       (data_byte),
    .is_final_byte   (is_final_byte),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .groups_per_line (groups_per_line),
    .queue_full      (queue_full),
    .push            (push),
    .push_job        (push_job)
  );

  sbte_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .full     (queue_full),
    .empty    (queue_empty),
    .head     (head)
  );

  sbte_back u_back (
    .clk           (clk),
    .rst           (rst),
    .empty         (queue_empty),
    .head          (head),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .text_char     (text_char),
    .is_final_char (is_final_char)
  );

endmodule

[rtl/core/sbte_front.sv]
module sbte_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        data_byte,
  input  logic              is_final_byte,
  input  logic              cfg_valid,
  input  logic              cfg_ready,
  input  logic [5:0]        groups_per_line,
  input  logic              queue_full,
  output logic              push,
  output sbte_pkg::job_t    push_job
);

  logic [5:0] line_groups;
  logic [7:0] first_byte;
  logic [7:0] second_byte;
  logic [1:0] count;
  logic [5:0] groups_on_line;
  logic [5:0] groups_on_line_next;
  logic       accept;
  logic       group_done;
  logic       newline;

  assign in_stall            = queue_full;
  assign accept              = in_valid && !in_stall;
  assign group_done          = (count == 2'd2);
  assign groups_on_line_next = groups_on_line + 6'd1;
  assign newline             = (groups_on_line_next == line_groups);
  assign push                = accept && (group_done || is_final_byte);

  always_comb begin
    push_job.final_job = is_final_byte;
    if (group_done) begin
      push_job.a        = first_byte;
      push_job.b        = second_byte;
      push_job.c        = data_byte;
      push_job.last_idx = newline ? sbte_pkg::CI_NEWLINE : sbte_pkg::CI_FOURTH;
    end else if (count == 2'd0) begin
      push_job.a        = data_byte;
      push_job.b        = 8'd0;
      push_job.c        = 8'd0;
      push_job.last_idx = sbte_pkg::CI_SECOND;
    end else begin
      push_job.a        = first_byte;
      push_job.b        = data_byte;
      push_job.c        = 8'd0;
      push_job.last_idx = sbte_pkg::CI_THIRD;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_groups <= sbte_pkg::LINE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      line_groups <= groups_per_line;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count          <= 2'd0;
      groups_on_line <= 6'd0;
    end else if (accept) begin
      if (is_final_byte) begin
        count          <= 2'd0;
        groups_on_line <= 6'd0;
      end else if (group_done) begin
        count          <= 2'd0;
        groups_on_line <= newline ? 6'd0 : groups_on_line_next;
      end else begin
        count <= count + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !is_final_byte && !group_done) begin
      if (count == 2'd0) begin
        first_byte <= data_byte;
      end else begin
        second_byte <= data_byte;
      end
    end
  end

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count != 2'd3)
    else $error("pending byte count out of range");
  a_final_clears: assert property (@(posedge clk) disable iff (rst)
    accept && is_final_byte |=> count == 2'd0 && groups_on_line == 6'd0)
    else $error("message state not cleared after final byte");
`endif

endmodule

[rtl/core/sbte_queue.sv]
module sbte_queue #(
  parameter int DEPTH = sbte_pkg::QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  sbte_pkg::job_t push_job,
  input  logic           pop,
  output logic           full,
  output logic           empty,
  output sbte_pkg::job_t head
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  sbte_pkg::job_t entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
    wrap_inc = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  assign full  = (count == CNT_W'(DEPTH));
  assign empty = (count == '0);
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wrap_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= wrap_inc(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && full))
    else $error("request written into a full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    !(pop && empty))
    else $error("request taken from an empty queue");
`endif

endmodule

[rtl/core/sbte_back.sv]
module sbte_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           empty,
  input  sbte_pkg::job_t head,
  output logic           pop,
  output logic           out_valid,
  input  logic           out_stall,
  output logic [7:0]     text_char,
  output logic           is_final_char
);

  logic [2:0] idx;
  logic [5:0] six;
  logic [7:0] char_value;
  logic       emit;
  logic       last_char;

  always_comb begin
    case (idx)
      sbte_pkg::CI_FIRST:  six = head.a[7:2];
      sbte_pkg::CI_SECOND: six = {head.a[1:0], head.b[7:4]};
      sbte_pkg::CI_THIRD:  six = {head.b[3:0], head.c[7:6]};
      default:             six = head.c[5:0];
    endcase
  end

  assign char_value = (idx == sbte_pkg::CI_NEWLINE) ? sbte_pkg::NEWLINE_CHAR
                                                    : {2'b00, six} + sbte_pkg::CHAR_OFFSET;
  assign emit       = !empty && (!out_valid || !out_stall);
  assign last_char  = (idx == head.last_idx);
  assign pop        = emit && last_char;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= sbte_pkg::CI_FIRST;
    end else if (emit) begin
      out_valid <= 1'b1;
      idx       <= last_char ? sbte_pkg::CI_FIRST : idx + 3'd1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      text_char     <= char_value;
      is_final_char <= last_char && head.final_job;
    end
  end

`ifndef SYNTHESIS
  a_idx_bound: assert property (@(posedge clk) disable iff (rst)
    !empty |-> idx <= head.last_idx)
    else $error("character index past the end of the request");
  a_idle_idx: assert property (@(posedge clk) disable iff (rst)
    empty |-> idx == sbte_pkg::CI_FIRST)
    else $error("character index left mid-request with nothing queued");
`endif

endmodule

[verif/six_bit_text_encoder_checker.sv]
module six_bit_text_encoder_checker (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [7:0] data_byte,
  input  logic       is_final_byte,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic [7:0] text_char,
  input  logic       is_final_char,
  input  logic       cfg_valid,
  input  logic       cfg_ready,
  input  logic [5:0] groups_per_line,
  output int         chars_owed,
  output int         mismatches
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0] ch;
    logic       ends_text;
  } text_char_t;

  text_char_t pending_text[$];
  text_char_t want;
  logic [5:0] line_setting;
  logic [7:0] held_first;
  logic [7:0] held_second;
  logic [1:0] held_count;
  logic [5:0] groups_done;
  int         errors;

  initial begin
    chars_owed = 0;
    mismatches = 0;
    errors = 0;
  end

  task automatic push_six(input logic [5:0] bits);
    pending_text.push_back('{ch: {2'b00, bits} + sbte_pkg::CHAR_OFFSET, ends_text: 1'b0});
  endtask

  task automatic clear_message();
    held_first = '0;
    held_second = '0;
    held_count = '0;
    groups_done = '0;
  endtask

  task automatic encode_byte(input logic [7:0] b, input logic last);
    int queued;
    text_char_t tail;
    queued = pending_text.size();
    if (held_count == 2'd2) begin
      push_six(held_first[7:2]);
      push_six({held_first[1:0], held_second[7:4]});
      push_six({held_second[3:0], b[7:6]});
      push_six(b[5:0]);
      groups_done = groups_done + 6'd1;
      if (groups_done == line_setting) begin
        pending_text.push_back('{ch: sbte_pkg::NEWLINE_CHAR, ends_text: 1'b0});
        groups_done = '0;
      end
      held_count = '0;
      held_first = '0;
      held_second = '0;
    end else if (last) begin
      if (held_count == 2'd0) begin
        push_six(b[7:2]);
        push_six({b[1:0], 4'b0000});
      end else begin
        push_six(held_first[7:2]);
        push_six({held_first[1:0], b[7:4]});
        push_six({b[3:0], 2'b00});
      end
    end else if (held_count == 2'd0) begin
      held_first = b;
      held_count = 2'd1;
    end else begin
      held_second = b;
      held_count = 2'd2;
    end
    if (last) begin
      if (pending_text.size() > queued) begin
        tail = pending_text.pop_back();
        tail.ends_text = 1'b1;
        pending_text.push_back(tail);
      end
      clear_message();
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      line_setting = sbte_pkg::LINE_RESET;
      clear_message();
      pending_text.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        line_setting = groups_per_line;
      end
      if (in_valid && !in_stall) begin
        encode_byte(data_byte, is_final_byte);
      end
      if (out_valid && !out_stall) begin
        if (pending_text.size() == 0) begin
          errors++;
          $error("text_char: no character expected, got %0d", text_char);
        end else begin
          want = pending_text.pop_front();
          if (text_char !== want.ch) begin
            errors++;
            $error("text_char: expected %0d, got %0d", want.ch, text_char);
          end
          if (is_final_char !== want.ends_text) begin
            errors++;
            $error("is_final_char: expected %0d, got %0d", want.ends_text, is_final_char);
          end
        end
      end
    end
    chars_owed <= pending_text.size();
    mismatches <= errors;
  end

endmodule

[verif/tb_six_bit_text_encoder_unit.sv]
module tb_six_bit_text_encoder_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 400000;

  logic       clk;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] data_byte = '0;
  logic       is_final_byte = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b1;
  logic [7:0] text_char;
  logic       is_final_char;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [5:0] groups_per_line = sbte_pkg::LINE_RESET;

  int   chars_owed;
  int   mismatches;
  int   cycle_count = 0;
  int   msg_left = 0;
  logic no_idle = 1'b0;

  six_bit_text_encoder_unit i_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .data_byte      (data_byte),
    .is_final_byte  (is_final_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .text_char      (text_char),
    .is_final_char  (is_final_char),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .groups_per_line(groups_per_line)
  );

  six_bit_text_encoder_checker i_checker (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .data_byte      (data_byte),
    .is_final_byte  (is_final_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .text_char      (text_char),
    .is_final_char  (is_final_char),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .groups_per_line(groups_per_line),
    .chars_owed     (chars_owed),
    .mismatches     (mismatches)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  function automatic int idle_cycles();
    if (no_idle) begin
      return 0;
    end
    return $urandom_range(17, 0);
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    gap = idle_cycles();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    data_byte <= b;
    is_final_byte <= last;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic stream_byte();
    if (msg_left == 0) begin
      msg_left = ($urandom_range(9, 0) == 0) ? $urandom_range(200, 30) : $urandom_range(10, 1);
    end
    msg_left = msg_left - 1;
    send_byte(8'($urandom_range(255, 0)), msg_left == 0);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (chars_owed != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_line_setting(input logic [5:0] setting);
    drain();
    cfg_valid <= 1'b1;
    groups_per_line <= setting;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int gap;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      gap = idle_cycles();
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin
    logic [5:0] setting;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    send_byte(8'hFF, 1'b1);
    send_byte(8'h00, 1'b1);
    send_byte(8'hA5, 1'b0);
    send_byte(8'h5A, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFC, 1'b0);
    send_byte(8'h0F, 1'b0);
    send_byte(8'hC3, 1'b1);

    msg_left = 66;
    repeat (70) stream_byte();
    while (msg_left != 0) stream_byte();

    write_line_setting(6'd1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h12, 1'b0);
    send_byte(8'h34, 1'b0);
    send_byte(8'h56, 1'b0);
    send_byte(8'h80, 1'b1);

    for (int p = 1; p <= 7; p++) begin
      case (p)
        1: setting = 6'd63;
        2: setting = 6'd0;
        3: setting = 6'd2;
        4: setting = 6'd1;
        7: setting = 6'd3;
        default: setting = 6'($urandom_range(63, 1));
      endcase
      write_line_setting(setting);
      no_idle = ($urandom_range(3, 0) == 0);
      repeat (30) stream_byte();
    end
    while (msg_left != 0) stream_byte();

    drain();
    repeat (8) @(posedge clk);
    if (mismatches == 0 && chars_owed == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/core/sbte_pkg.sv
rtl/core/sbte_front.sv
rtl/core/sbte_queue.sv
rtl/core/sbte_back.sv
rtl/core/six_bit_text_encoder_unit.sv
verif/six_bit_text_encoder_checker.sv
verif/tb_six_bit_text_encoder_unit.sv
